### hw/rtl/ledkp_pkg.sv
// Shared types, constants and helper functions for the two-channel LED dimmer.
// Holds the register map, the register reset values and the lamp state record.
// No dependencies.
package ledkp_pkg;

  localparam int unsigned LEVEL_W    = 10;
  localparam int unsigned HOLD_W     = 16;
  localparam int unsigned WAIT_W     = 8;
  localparam int unsigned RATE_W     = 6;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Register map
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_STEP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_CEILING = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_ON_LEVEL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IR_OVERRIDE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_VIS_OVERRIDE  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_MAX      = 3'd7;

  localparam logic [RATE_W-1:0] RATE_RESET = 6'd5;

  typedef struct packed {
    logic [LEVEL_W-1:0] level_step;
    logic [LEVEL_W-1:0] level_ceiling;
    logic [LEVEL_W-1:0] min_on_level;
    logic [HOLD_W-1:0]  long_press_ticks;
    logic [WAIT_W-1:0]  debounce_ticks;
    logic [LEVEL_W-1:0] ir_override_level;
    logic [LEVEL_W-1:0] vis_override_level;
    logic [RATE_W-1:0]  strobe_rate_max;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    level_step:         10'd50,
    level_ceiling:      10'd1000,
    min_on_level:       10'd30,
    long_press_ticks:   16'd500,
    debounce_ticks:     8'd20,
    ir_override_level:  10'd1000,
    vis_override_level: 10'd500,
    strobe_rate_max:    6'd20
  };

  // Brightness, channel, strobe and compare state
  typedef struct packed {
    logic [LEVEL_W-1:0] ir_level;
    logic [LEVEL_W-1:0] vis_level;
    logic               chan;
    logic               strobe_on;
    logic [RATE_W-1:0]  rate;
    logic               phase;
    logic [HOLD_W-1:0]  elapsed;
    logic [LEVEL_W-1:0] ir_out;
    logic [LEVEL_W-1:0] vis_out;
  } lamp_t;

  // One sampled tick word
  typedef struct packed {
    logic ext_ir;
    logic ext_vis;
    logic mode_key;
    logic up_key;
    logic down_key;
  } tick_t;

  // Drive zero for levels below the minimum
  function automatic logic [LEVEL_W-1:0] gated(logic [LEVEL_W-1:0] lvl,
                                               logic [LEVEL_W-1:0] min_on);
    return (lvl >= min_on) ? lvl : '0;
  endfunction

  // Show the selected channel, dark the other one
  function automatic lamp_t show_selected(lamp_t s, logic on, logic [LEVEL_W-1:0] min_on);
    lamp_t r;
    r = s;
    if (!s.chan) begin
      r.ir_out  = on ? gated(s.ir_level, min_on) : '0;
      r.vis_out = '0;
    end else begin
      r.vis_out = on ? gated(s.vis_level, min_on) : '0;
      r.ir_out  = '0;
    end
    return r;
  endfunction

  // Up press: raise strobe rate or level with clamping
  function automatic lamp_t key_up(lamp_t s, cfg_t c);
    lamp_t              r;
    logic [RATE_W-1:0]  mx;
    logic [RATE_W:0]    inc;
    logic [LEVEL_W-1:0] lv;
    logic [LEVEL_W:0]   sum;
    r = s;
    if (s.strobe_on) begin
      mx     = (c.strobe_rate_max != '0) ? c.strobe_rate_max : RATE_W'(1);
      inc    = {1'b0, s.rate} + (RATE_W+1)'(1);
      r.rate = (inc <= {1'b0, mx}) ? inc[RATE_W-1:0] : mx;
    end else begin
      lv  = s.chan ? s.vis_level : s.ir_level;
      sum = {1'b0, lv} + {1'b0, c.level_step};
      lv  = (sum <= {1'b0, c.level_ceiling}) ? sum[LEVEL_W-1:0] : c.level_ceiling;
      if (s.chan) r.vis_level = lv;
      else        r.ir_level  = lv;
      r = show_selected(r, 1'b1, c.min_on_level);
    end
    return r;
  endfunction

  // Down press: lower strobe rate or level, drop to zero near the floor
  function automatic lamp_t key_down(lamp_t s, cfg_t c);
    lamp_t              r;
    logic [LEVEL_W-1:0] lv;
    logic [LEVEL_W:0]   floor_sum;
    r = s;
    if (s.strobe_on) begin
      r.rate = (s.rate > RATE_W'(2)) ? s.rate - RATE_W'(1) : RATE_W'(1);
    end else begin
      lv        = s.chan ? s.vis_level : s.ir_level;
      floor_sum = {1'b0, c.level_step} + {1'b0, c.min_on_level};
      lv        = ({1'b0, lv} >= floor_sum) ? lv - c.level_step : '0;
      if (s.chan) r.vis_level = lv;
      else        r.ir_level  = lv;
      r = show_selected(r, 1'b1, c.min_on_level);
    end
    return r;
  endfunction

endpackage

### hw/rtl/two_channel_led_dimmer_keypad_control.sv
// Top level of the two-channel LED dimmer with keypad, override pins and strobe.
// Uses ledkp_pkg for the register map, the lamp state record and key helpers.
// Contains the tick sequencer and the restoring divider for the strobe period.
//
//   port group   direction  handshake                 contents
//   in_*         in         in_valid_i / in_stall_o    one tick word: pins and key levels
//   out_*        out        out_valid_o / out_stall_i  compares, channel, strobe, override
//   cfg_*        in         cfg_valid_i / cfg_ready_o  register index and write data
//
// From acceptance to the next acceptance each tick word passes through the pins and keys
// step, the one-bit-per-cycle divider that forms the strobe half period over DW quotient
// bits (DW is the bit count of TICKS_PER_SECOND), the finish step, and back to idle,
// where the next word is taken.
// The result register frees the input side: a new word is taken while a result waits.
// A stalled result holds the finish step until the result register is free.
// Reset is asynchronous, active low; the register port is always ready.
module two_channel_led_dimmer_keypad_control
  import ledkp_pkg::*;
#(
  parameter int unsigned TICKS_PER_SECOND = 1000
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // tick words
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  ext_ir_pin_i,
  input  logic                  ext_vis_pin_i,
  input  logic                  mode_key_i,
  input  logic                  up_key_i,
  input  logic                  down_key_i,
  // result words
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [LEVEL_W-1:0]    ir_compare_o,
  output logic [LEVEL_W-1:0]    vis_compare_o,
  output logic                  selected_channel_o,
  output logic                  strobe_active_o,
  output logic                  override_active_o,
  // register writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned DW    = $clog2(TICKS_PER_SECOND + 1);
  localparam int unsigned CNT_W = $clog2(DW);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DW - 1);
  localparam logic [DW-1:0]    DIVIDEND = DW'(TICKS_PER_SECOND);

  typedef enum logic [1:0] {
    S_IDLE,
    S_KEYS,
    S_DIV,
    S_FIN
  } state_e;

  state_e             state_q, state_d;
  cfg_t               cfg_q, cfg_d;
  lamp_t              lamp_q, lamp_d;
  tick_t              tick_q, tick_d;
  logic               blocked_q, blocked_d;
  logic               mode_prev_q, mode_prev_d;
  logic               up_prev_q, up_prev_d;
  logic               down_prev_q, down_prev_d;
  logic [HOLD_W-1:0]  hold_q, hold_d;
  logic [WAIT_W-1:0]  up_wcnt_q, up_wcnt_d;
  logic [WAIT_W-1:0]  down_wcnt_q, down_wcnt_d;
  logic [RATE_W-1:0]  rem_q, rem_d;
  logic [DW-1:0]      quo_q, quo_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  logic [LEVEL_W-1:0] out_ir_q, out_ir_d;
  logic [LEVEL_W-1:0] out_vis_q, out_vis_d;
  logic               out_chan_q, out_chan_d;
  logic               out_strobe_q, out_strobe_d;
  logic               out_ovr_q, out_ovr_d;

  assign in_stall_o         = (state_q != S_IDLE);
  assign cfg_ready_o        = 1'b1;
  assign out_valid_o        = out_valid_q;
  assign ir_compare_o       = out_ir_q;
  assign vis_compare_o      = out_vis_q;
  assign selected_channel_o = out_chan_q;
  assign strobe_active_o    = out_strobe_q;
  assign override_active_o  = out_ovr_q;

  // Next state of the sequencer, the divider and the lamp state
  always_comb begin : next_state
    lamp_t             s;
    logic              blk;
    logic              mp, upp, dnp;
    logic [HOLD_W-1:0] hold;
    logic [WAIT_W-1:0] uw, dw;
    logic [RATE_W:0]   trial, den;
    logic [HOLD_W-1:0] half;

    state_d      = state_q;
    cfg_d        = cfg_q;
    lamp_d       = lamp_q;
    tick_d       = tick_q;
    blocked_d    = blocked_q;
    mode_prev_d  = mode_prev_q;
    up_prev_d    = up_prev_q;
    down_prev_d  = down_prev_q;
    hold_d       = hold_q;
    up_wcnt_d    = up_wcnt_q;
    down_wcnt_d  = down_wcnt_q;
    rem_d        = rem_q;
    quo_d        = quo_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q;
    out_ir_d     = out_ir_q;
    out_vis_d    = out_vis_q;
    out_chan_d   = out_chan_q;
    out_strobe_d = out_strobe_q;
    out_ovr_d    = out_ovr_q;

    s     = lamp_q;
    blk   = blocked_q;
    mp    = mode_prev_q;
    upp   = up_prev_q;
    dnp   = down_prev_q;
    hold  = hold_q;
    uw    = up_wcnt_q;
    dw    = down_wcnt_q;
    den   = (lamp_q.rate != '0) ? {1'b0, lamp_q.rate} : (RATE_W+1)'(1);
    trial = {rem_q, quo_q[DW-1]};
    half  = HOLD_W'(quo_q >> 1);

    // Register writes
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_LEVEL_STEP:    cfg_d.level_step         = cfg_data_i[LEVEL_W-1:0];
        CFG_LEVEL_CEILING: cfg_d.level_ceiling      = cfg_data_i[LEVEL_W-1:0];
        CFG_MIN_ON_LEVEL:  cfg_d.min_on_level       = cfg_data_i[LEVEL_W-1:0];
        CFG_LONG_PRESS:    cfg_d.long_press_ticks   = cfg_data_i[HOLD_W-1:0];
        CFG_DEBOUNCE:      cfg_d.debounce_ticks     = cfg_data_i[WAIT_W-1:0];
        CFG_IR_OVERRIDE:   cfg_d.ir_override_level  = cfg_data_i[LEVEL_W-1:0];
        CFG_VIS_OVERRIDE:  cfg_d.vis_override_level = cfg_data_i[LEVEL_W-1:0];
        CFG_RATE_MAX:      cfg_d.strobe_rate_max    = cfg_data_i[RATE_W-1:0];
        default: ;
      endcase
    end

    // Drop the result word once taken
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          tick_d  = '{ext_ir: ext_ir_pin_i, ext_vis: ext_vis_pin_i, mode_key: mode_key_i,
                      up_key: up_key_i, down_key: down_key_i};
          state_d = S_KEYS;
        end
      end

      S_KEYS: begin
        // Advance both tick counters
        if (hold != '1)      hold      = hold + HOLD_W'(1);
        if (s.elapsed != '1) s.elapsed = s.elapsed + HOLD_W'(1);

        // Decode the override pins
        if (tick_q.ext_ir && tick_q.ext_vis) begin
          s.ir_out  = '0;
          s.vis_out = '0;
          blk       = 1'b0;
        end else if (tick_q.ext_ir) begin
          s.strobe_on = 1'b0;
          s.vis_out   = '0;
          s.ir_out    = cfg_q.ir_override_level;
          blk         = 1'b1;
        end else if (tick_q.ext_vis) begin
          s.strobe_on = 1'b0;
          s.ir_out    = '0;
          s.vis_out   = cfg_q.vis_override_level;
          blk         = 1'b1;
        end else begin
          blk = 1'b0;
        end

        if (!blk) begin
          // Mode key: restart hold on press, act on release
          if (mp && !tick_q.mode_key) begin
            hold = '0;
          end else if (!mp && tick_q.mode_key) begin
            if (hold >= cfg_q.long_press_ticks) begin
              s.strobe_on = ~s.strobe_on;
              if (s.strobe_on) begin
                s.ir_out  = '0;
                s.vis_out = '0;
                s.phase   = 1'b0;
                s.elapsed = '0;
              end else begin
                s = show_selected(s, 1'b1, cfg_q.min_on_level);
              end
            end else if (!s.strobe_on) begin
              s.chan = ~s.chan;
              s      = show_selected(s, 1'b1, cfg_q.min_on_level);
            end
          end
          mp = tick_q.mode_key;

          // Up key: debounce recheck, then falling edge
          if (uw != '0) begin
            uw = uw - WAIT_W'(1);
            if (uw == '0 && !tick_q.up_key) s = key_up(s, cfg_q);
          end
          if (upp && !tick_q.up_key) begin
            if (cfg_q.debounce_ticks == '0) s = key_up(s, cfg_q);
            else                            uw = cfg_q.debounce_ticks;
          end
          upp = tick_q.up_key;

          // Down key: same scheme on the updated state
          if (dw != '0) begin
            dw = dw - WAIT_W'(1);
            if (dw == '0 && !tick_q.down_key) s = key_down(s, cfg_q);
          end
          if (dnp && !tick_q.down_key) begin
            if (cfg_q.debounce_ticks == '0) s = key_down(s, cfg_q);
            else                            dw = cfg_q.debounce_ticks;
          end
          dnp = tick_q.down_key;
        end

        lamp_d      = s;
        blocked_d   = blk;
        mode_prev_d = mp;
        up_prev_d   = upp;
        down_prev_d = dnp;
        hold_d      = hold;
        up_wcnt_d   = uw;
        down_wcnt_d = dw;

        // Load the divider with the tick rate
        rem_d   = '0;
        quo_d   = DIVIDEND;
        cnt_d   = '0;
        state_d = S_DIV;
      end

      S_DIV: begin
        // One restoring step per cycle
        if (trial >= den) begin
          rem_d = RATE_W'(trial - den);
          quo_d = {quo_q[DW-2:0], 1'b1};
        end else begin
          rem_d = trial[RATE_W-1:0];
          quo_d = {quo_q[DW-2:0], 1'b0};
        end
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) state_d = S_FIN;
      end

      S_FIN: begin
        // Service the strobe and publish once the result register is free
        if (!(out_valid_q && out_stall_i)) begin
          if (s.strobe_on && (s.elapsed >= half)) begin
            s.elapsed = '0;
            s.phase   = ~s.phase;
            s         = show_selected(s, s.phase, cfg_q.min_on_level);
          end
          lamp_d       = s;
          out_valid_d  = 1'b1;
          out_ir_d     = s.ir_out;
          out_vis_d    = s.vis_out;
          out_chan_d   = s.chan;
          out_strobe_d = s.strobe_on;
          out_ovr_d    = blocked_q;
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // State, registers and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cfg_q        <= CFG_RESET;
      lamp_q       <= '{ir_level: '0, vis_level: '0, chan: 1'b0, strobe_on: 1'b0,
                        rate: RATE_RESET, phase: 1'b0, elapsed: '0, ir_out: '0,
                        vis_out: '0};
      tick_q       <= '0;
      blocked_q    <= 1'b0;
      mode_prev_q  <= 1'b1;
      up_prev_q    <= 1'b1;
      down_prev_q  <= 1'b1;
      hold_q       <= '0;
      up_wcnt_q    <= '0;
      down_wcnt_q  <= '0;
      rem_q        <= '0;
      quo_q        <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      out_ir_q     <= '0;
      out_vis_q    <= '0;
      out_chan_q   <= 1'b0;
      out_strobe_q <= 1'b0;
      out_ovr_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      cfg_q        <= cfg_d;
      lamp_q       <= lamp_d;
      tick_q       <= tick_d;
      blocked_q    <= blocked_d;
      mode_prev_q  <= mode_prev_d;
      up_prev_q    <= up_prev_d;
      down_prev_q  <= down_prev_d;
      hold_q       <= hold_d;
      up_wcnt_q    <= up_wcnt_d;
      down_wcnt_q  <= down_wcnt_d;
      rem_q        <= rem_d;
      quo_q        <= quo_d;
      cnt_q        <= cnt_d;
      out_valid_q  <= out_valid_d;
      out_ir_q     <= out_ir_d;
      out_vis_q    <= out_vis_d;
      out_chan_q   <= out_chan_d;
      out_strobe_q <= out_strobe_d;
      out_ovr_q    <= out_ovr_d;
    end
  end

  // An accepted word keeps the input side busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input side free right after accepting a word");

  // A new result word only comes from the finish step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FIN))
    else $error("result word raised outside the finish step");

  // An override that blocks the keys has cancelled strobe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    blocked_q |-> !lamp_q.strobe_on)
    else $error("strobe on while keys are blocked");

  // The divisor never reaches zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lamp_q.rate != '0)
    else $error("strobe rate reached zero");

endmodule

### test/dimmer_checker.sv
// Checker for the two-channel LED dimmer: watches the tick, result and register channels.
// Keeps its own lamp state, predicts one result word per tick and compares field by field.
// Depends on ledkp_pkg for widths, the register map and the register record.
module dimmer_checker
  import ledkp_pkg::*;
#(
  parameter int unsigned TICKS_PER_SECOND = 1000
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic                  ext_ir_pin_i,
  input  logic                  ext_vis_pin_i,
  input  logic                  mode_key_i,
  input  logic                  up_key_i,
  input  logic                  down_key_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [LEVEL_W-1:0]    ir_compare_i,
  input  logic [LEVEL_W-1:0]    vis_compare_i,
  input  logic                  selected_channel_i,
  input  logic                  strobe_active_i,
  input  logic                  override_active_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  localparam int KEY_UP      = 0;
  localparam int KEY_DOWN    = 1;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic [LEVEL_W-1:0] ir;
    logic [LEVEL_W-1:0] vis;
    logic               chan;
    logic               strobe;
    logic               ovr;
  } lamp_word_t;

  // Register copy and lamp state as the block should hold them
  cfg_t               regs;
  logic [LEVEL_W-1:0] ir_lvl, vis_lvl, ir_cmp, vis_cmp;
  logic               chan, strobe, phase, blocked, mode_prev;
  logic [RATE_W-1:0]  rate;
  logic [HOLD_W-1:0]  elapsed, hold_cnt;
  logic [WAIT_W-1:0]  key_wait [2];
  logic               key_prev [2];

  lamp_word_t lamp_words_due [$];
  lamp_word_t got, want, next_word;
  int         words_seen;

  // Print one line per mismatch, up to a cap, and count every one
  task automatic report_mismatch(string what, int unsigned got_v, int unsigned want_v);
    fail_count_o++;
    if (fail_count_o <= MAX_REPORTS)
      $display("%0t: result word %0d, %s: got %0d, want %0d", $time, words_seen, what,
               got_v, want_v);
  endtask

  // Zero a level below the minimum
  function automatic logic [LEVEL_W-1:0] lit(logic [LEVEL_W-1:0] lvl);
    return (lvl >= regs.min_on_level) ? lvl : '0;
  endfunction

  // Light the selected channel (or dark it) and dark the other one
  task automatic show(logic on);
    if (!chan) begin
      ir_cmp  = on ? lit(ir_lvl) : '0;
      vis_cmp = '0;
    end else begin
      vis_cmp = on ? lit(vis_lvl) : '0;
      ir_cmp  = '0;
    end
  endtask

  // Step the strobe rate or the selected level by one key action
  task automatic step_level(bit up);
    int unsigned lv, top_rate;
    if (strobe) begin
      if (up) begin
        top_rate = (regs.strobe_rate_max != 0) ? regs.strobe_rate_max : 1;
        rate     = RATE_W'((rate + 1 <= top_rate) ? rate + 1 : top_rate);
      end else begin
        rate = RATE_W'((rate > 2) ? rate - 1 : 1);
      end
    end else begin
      lv = chan ? vis_lvl : ir_lvl;
      if (up)
        lv = (lv + regs.level_step <= regs.level_ceiling) ? lv + regs.level_step
                                                           : regs.level_ceiling;
      else
        lv = (lv >= regs.level_step + regs.min_on_level) ? lv - regs.level_step : 0;
      if (chan) vis_lvl = LEVEL_W'(lv);
      else      ir_lvl  = LEVEL_W'(lv);
      show(1'b1);
    end
  endtask

  // Run the debounce wait of one level key and act on an edge or a recheck
  task automatic service_level_key(int k, logic level);
    if (key_wait[k] != 0) begin
      key_wait[k]--;
      if (key_wait[k] == 0 && !level) step_level(k == KEY_UP);
    end
    if (key_prev[k] && !level) begin
      if (regs.debounce_ticks == 0) step_level(k == KEY_UP);
      else                          key_wait[k] = regs.debounce_ticks;
    end
    key_prev[k] = level;
  endtask

  // Advance the lamp state by one tick and form the result word
  task automatic advance_lamp(input tick_t t, output lamp_word_t w);
    int unsigned r, half;
    if (hold_cnt != '1) hold_cnt++;
    if (elapsed != '1)  elapsed++;

    // decode the override pins
    if (t.ext_ir && t.ext_vis) begin
      ir_cmp  = '0;
      vis_cmp = '0;
      blocked = 1'b0;
    end else if (t.ext_ir) begin
      strobe  = 1'b0;
      vis_cmp = '0;
      ir_cmp  = regs.ir_override_level;
      blocked = 1'b1;
    end else if (t.ext_vis) begin
      strobe  = 1'b0;
      ir_cmp  = '0;
      vis_cmp = regs.vis_override_level;
      blocked = 1'b1;
    end else begin
      blocked = 1'b0;
    end

    // handle the keys unless an override holds them off
    if (!blocked) begin
      if (mode_prev && !t.mode_key) begin
        hold_cnt = '0;
      end else if (!mode_prev && t.mode_key) begin
        if (hold_cnt >= regs.long_press_ticks) begin
          strobe = !strobe;
          if (strobe) begin
            ir_cmp  = '0;
            vis_cmp = '0;
            phase   = 1'b0;
            elapsed = '0;
          end else begin
            show(1'b1);
          end
        end else if (!strobe) begin
          chan = !chan;
          show(1'b1);
        end
      end
      mode_prev = t.mode_key;
      service_level_key(KEY_UP, t.up_key);
      service_level_key(KEY_DOWN, t.down_key);
    end

    // flip the strobe phase once half a period has passed
    if (strobe) begin
      r    = (rate != 0) ? rate : 1;
      half = (TICKS_PER_SECOND / r) / 2;
      if (elapsed >= half) begin
        elapsed = '0;
        phase   = !phase;
        show(phase);
      end
    end

    w = {ir_cmp, vis_cmp, chan, strobe, blocked};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs        = CFG_RESET;
      ir_lvl      = '0;
      vis_lvl     = '0;
      ir_cmp      = '0;
      vis_cmp     = '0;
      chan        = 1'b0;
      strobe      = 1'b0;
      phase       = 1'b0;
      blocked     = 1'b0;
      mode_prev   = 1'b1;
      rate        = RATE_RESET;
      elapsed     = '0;
      hold_cnt    = '0;
      key_wait[0] = '0;
      key_wait[1] = '0;
      key_prev[0] = 1'b1;
      key_prev[1] = 1'b1;
      lamp_words_due.delete();
      words_seen   = 0;
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // track register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_LEVEL_STEP:    regs.level_step         = cfg_data_i[LEVEL_W-1:0];
          CFG_LEVEL_CEILING: regs.level_ceiling      = cfg_data_i[LEVEL_W-1:0];
          CFG_MIN_ON_LEVEL:  regs.min_on_level       = cfg_data_i[LEVEL_W-1:0];
          CFG_LONG_PRESS:    regs.long_press_ticks   = cfg_data_i[HOLD_W-1:0];
          CFG_DEBOUNCE:      regs.debounce_ticks     = cfg_data_i[WAIT_W-1:0];
          CFG_IR_OVERRIDE:   regs.ir_override_level  = cfg_data_i[LEVEL_W-1:0];
          CFG_VIS_OVERRIDE:  regs.vis_override_level = cfg_data_i[LEVEL_W-1:0];
          CFG_RATE_MAX:      regs.strobe_rate_max    = cfg_data_i[RATE_W-1:0];
          default: ;
        endcase
      end

      // compare an accepted result word with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        got = {ir_compare_i, vis_compare_i, selected_channel_i, strobe_active_i,
               override_active_i};
        if (lamp_words_due.size() == 0) begin
          report_mismatch("word with no tick pending, ir_compare", got.ir, 0);
        end else begin
          want = lamp_words_due.pop_front();
          if (got.ir != want.ir)         report_mismatch("ir_compare", got.ir, want.ir);
          if (got.vis != want.vis)       report_mismatch("vis_compare", got.vis, want.vis);
          if (got.chan != want.chan)     report_mismatch("selected_channel", got.chan,
                                                         want.chan);
          if (got.strobe != want.strobe) report_mismatch("strobe_active", got.strobe,
                                                         want.strobe);
          if (got.ovr != want.ovr)       report_mismatch("override_active", got.ovr,
                                                         want.ovr);
        end
        words_seen++;
      end

      // predict the word for an accepted tick
      if (in_valid_i && !in_stall_i) begin
        advance_lamp({ext_ir_pin_i, ext_vis_pin_i, mode_key_i, up_key_i, down_key_i},
                     next_word);
        lamp_words_due.push_back(next_word);
      end

      pending_o = lamp_words_due.size();
    end
  end

endmodule

### test/tb_top.sv
// Testbench top for the two-channel LED dimmer: clock, reset, tick and register stimulus.
// Instantiates the block and dimmer_checker beside it, then gives the verdict.
// Depends on ledkp_pkg and on the block's top level.
module tb_top;
  import ledkp_pkg::*;

  localparam int unsigned TICK_RATE   = 1000;
  localparam int          SET_TICKS   = 140;
  localparam int          HOLD_CYCLES = 300;
  localparam int          CYCLE_LIMIT = 800000;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid, in_stall;
  logic                  ext_ir, ext_vis, mode_key, up_key, down_key;
  logic                  out_valid, out_stall;
  logic [LEVEL_W-1:0]    ir_compare, vis_compare;
  logic                  selected_channel, strobe_active, override_active;
  logic                  cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int          fail_count, pending;
  int          cycles = 0;
  int          ticks_done = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_req = 1'b0;
  cfg_t        cur;
  int          mark;
  bit          held, paused;

  two_channel_led_dimmer_keypad_control #(
    .TICKS_PER_SECOND(TICK_RATE)
  ) dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .ext_ir_pin_i       (ext_ir),
    .ext_vis_pin_i      (ext_vis),
    .mode_key_i         (mode_key),
    .up_key_i           (up_key),
    .down_key_i         (down_key),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .ir_compare_o       (ir_compare),
    .vis_compare_o      (vis_compare),
    .selected_channel_o (selected_channel),
    .strobe_active_o    (strobe_active),
    .override_active_o  (override_active),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data)
  );

  dimmer_checker #(
    .TICKS_PER_SECOND(TICK_RATE)
  ) u_check (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_stall_i         (in_stall),
    .ext_ir_pin_i       (ext_ir),
    .ext_vis_pin_i      (ext_vis),
    .mode_key_i         (mode_key),
    .up_key_i           (up_key),
    .down_key_i         (down_key),
    .out_valid_i        (out_valid),
    .out_stall_i        (out_stall),
    .ir_compare_i       (ir_compare),
    .vis_compare_i      (vis_compare),
    .selected_channel_i (selected_channel),
    .strobe_active_i    (strobe_active),
    .override_active_i  (override_active),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_i        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .fail_count_o       (fail_count),
    .pending_o          (pending)
  );

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Drive the result stall: random, or one long hold-off on request
  initial begin
    bit hold_taken;
    hold_taken = 1'b0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Offer one tick word, hold it until accepted, then drop valid; idle first at random
  task automatic send_tick(bit pa, bit pb, bit mk, bit uk, bit dk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    ext_ir   <= pa;
    ext_vis  <= pb;
    mode_key <= mk;
    up_key   <= uk;
    down_key <= dk;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    in_valid <= 1'b0;
    @(negedge clk);
    ticks_done++;
  endtask

  // Hold until every predicted word has come out
  task automatic wait_drained();
    while (pending != 0) @(negedge clk);
  endtask

  // Write one register; leaves valid high for a following write
  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Load a full register set once the block is idle
  task automatic apply_cfg(cfg_t c);
    wait_drained();
    repeat (4) @(negedge clk);
    put_reg(CFG_LEVEL_STEP,    CFG_DATA_W'(c.level_step));
    put_reg(CFG_LEVEL_CEILING, CFG_DATA_W'(c.level_ceiling));
    put_reg(CFG_MIN_ON_LEVEL,  CFG_DATA_W'(c.min_on_level));
    put_reg(CFG_LONG_PRESS,    c.long_press_ticks);
    put_reg(CFG_DEBOUNCE,      CFG_DATA_W'(c.debounce_ticks));
    put_reg(CFG_IR_OVERRIDE,   CFG_DATA_W'(c.ir_override_level));
    put_reg(CFG_VIS_OVERRIDE,  CFG_DATA_W'(c.vis_override_level));
    put_reg(CFG_RATE_MAX,      CFG_DATA_W'(c.strobe_rate_max));
    cfg_valid <= 1'b0;
    cur = c;
  endtask

  // Register sets: low extremes, high extremes, reset values, then random
  function automatic cfg_t pick_cfg(int set_no);
    cfg_t c;
    case (set_no)
      0: begin
        c.level_step         = 10'd1;
        c.level_ceiling      = 10'd1;
        c.min_on_level       = 10'd0;
        c.long_press_ticks   = 16'd1;
        c.debounce_ticks     = 8'd0;
        c.ir_override_level  = 10'd0;
        c.vis_override_level = 10'd0;
        c.strobe_rate_max    = 6'd2;
      end
      1: begin
        c.level_step         = 10'd1023;
        c.level_ceiling      = 10'd1023;
        c.min_on_level       = 10'd1023;
        c.long_press_ticks   = 16'd65535;
        c.debounce_ticks     = 8'd255;
        c.ir_override_level  = 10'd1023;
        c.vis_override_level = 10'd1023;
        c.strobe_rate_max    = 6'd63;
      end
      2: c = CFG_RESET;
      default: begin
        c.level_step         = LEVEL_W'($urandom_range(1, 300));
        c.level_ceiling      = LEVEL_W'($urandom_range(150, 1023));
        c.min_on_level       = LEVEL_W'($urandom_range(0, 150));
        c.long_press_ticks   = HOLD_W'($urandom_range(1, 40));
        c.debounce_ticks     = WAIT_W'($urandom_range(0, 6));
        c.ir_override_level  = LEVEL_W'($urandom_range(0, 1023));
        c.vis_override_level = LEVEL_W'($urandom_range(0, 1023));
        c.strobe_rate_max    = RATE_W'($urandom_range(2, 63));
      end
    endcase
    return c;
  endfunction

  // Play one stretch of ticks: key presses, overrides, quiet time or noise
  task automatic play_scenario();
    int          kind, pins, len;
    int unsigned lp, db;
    bit          up_sel, both, uk, dk;
    kind = $urandom_range(0, 99);
    lp   = cur.long_press_ticks;
    db   = cur.debounce_ticks;
    if (kind < 10) begin
      // random levels on every line
      repeat ($urandom_range(1, 4))
        send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
    end else if (kind < 22) begin
      // override request with keys rattling underneath
      pins = $urandom_range(1, 3);
      repeat ($urandom_range(1, 6))
        send_tick(pins[1], pins[0], 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      send_tick(1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
    end else if (kind < 42) begin
      // mode press, short or around the long-press threshold
      if (lp <= 64) begin
        case ($urandom_range(0, 3))
          0:       len = $urandom_range(1, 3);
          1:       len = (lp > 1) ? lp - 1 : 1;
          2:       len = lp;
          default: len = lp + 1;
        endcase
      end else if (lp <= 600 && $urandom_range(0, 9) == 0) begin
        len = lp;
      end else begin
        len = $urandom_range(1, 3);
      end
      repeat (len) send_tick(1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
      send_tick(1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
    end else if (kind < 80) begin
      // up or down press around the debounce time, sometimes bouncing first
      up_sel = 1'($urandom_range(0, 1));
      both   = ($urandom_range(0, 9) == 0);
      uk     = !(up_sel || both);
      dk     = !(!up_sel || both);
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 2)) send_tick(1'b0, 1'b0, 1'b1, uk, dk);
        send_tick(1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
      end
      case ($urandom_range(0, 3))
        0:       len = $urandom_range(1, 3);
        1:       len = (db > 1) ? db : 1;
        2:       len = db + 1;
        default: len = db + 2;
      endcase
      repeat (len) send_tick(1'b0, 1'b0, 1'b1, uk, dk);
      send_tick(1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
    end else begin
      repeat ($urandom_range(1, 8)) send_tick(1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
    end
  endtask

  initial begin
    cfg_t dir;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    ext_ir    = 1'b0;
    ext_vis   = 1'b0;
    mode_key  = 1'b1;
    up_key    = 1'b1;
    down_key  = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    held      = 1'b0;
    paused    = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 32;
    recv_idle_pct = 81;

    // directed ticks: short long-press threshold, keys act on the edge
    dir                  = CFG_RESET;
    dir.long_press_ticks = 16'd3;
    dir.debounce_ticks   = 8'd0;
    apply_cfg(dir);
    send_tick(1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
    send_tick(1'b1, 1'b1, 1'b1, 1'b1, 1'b1);  // both pins: dark, keys live
    send_tick(1'b1, 1'b0, 1'b1, 1'b1, 1'b1);  // infrared request
    send_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0);  // keys ignored while blocked
    send_tick(1'b0, 1'b1, 1'b1, 1'b1, 1'b1);  // visible request
    send_tick(1'b0, 1'b0, 1'b1, 1'b1, 1'b1);  // override values persist
    send_tick(1'b0, 1'b0, 1'b1, 1'b0, 1'b1);  // up acts at once
    send_tick(1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
    send_tick(1'b0, 1'b0, 1'b1, 1'b1, 1'b0);  // down near floor drops to zero
    send_tick(1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
    send_tick(1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
    send_tick(1'b0, 1'b0, 1'b1, 1'b1, 1'b1);  // short press swaps channel
    send_tick(1'b0, 1'b0, 1'b1, 1'b0, 1'b1);  // up on visible
    send_tick(1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
    repeat (3) send_tick(1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
    send_tick(1'b0, 1'b0, 1'b1, 1'b1, 1'b1);  // long press enters strobe
    send_tick(1'b0, 1'b0, 1'b1, 1'b0, 1'b1);  // rate up
    send_tick(1'b0, 1'b0, 1'b1, 1'b1, 1'b0);  // rate down
    send_tick(1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
    send_tick(1'b0, 1'b1, 1'b1, 1'b1, 1'b1);  // request cancels strobe
    send_tick(1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
    send_tick(1'b1, 1'b1, 1'b0, 1'b0, 1'b0);  // both pins with all keys down
    send_tick(1'b0, 1'b0, 1'b1, 1'b1, 1'b1);

    // random part: three idling phases, three register sets each
    for (int set_no = 0; set_no < 9; set_no++) begin
      case (set_no / 3)
        0: begin
          send_idle_pct = 32;
          recv_idle_pct = 81;
        end
        1: begin
          send_idle_pct = 81;
          recv_idle_pct = 32;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      apply_cfg(pick_cfg(set_no));
      mark = ticks_done;
      while (ticks_done - mark < SET_TICKS) begin
        // long result hold-off while ticks keep coming
        if (set_no == 7 && !held && ticks_done - mark >= SET_TICKS / 3) begin
          hold_req = 1'b1;
          held     = 1'b1;
        end
        // let the pipeline run dry mid-stream
        if (set_no == 4 && !paused && ticks_done - mark >= SET_TICKS / 2) begin
          wait_drained();
          paused = 1'b1;
        end
        play_scenario();
      end
    end
    in_valid <= 1'b0;

    wait_drained();
    repeat (40) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
